FILE: hdl/gmf_pkg.sv
// Shared types and codes for the gzip member framer.
`default_nettype none
package gmf_pkg;

    localparam logic [1:0] OP_DATA     = 2'd0;
    localparam logic [1:0] OP_END      = 2'd1;
    localparam logic [1:0] OP_INFL_END = 2'd2;

    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_PAYLOAD = 2'd1;
    localparam logic [1:0] CLS_TRAILER = 2'd2;
    localparam logic [1:0] CLS_IGNORED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CLEAN     = 3'd1;
    localparam logic [2:0] ST_NOT_GZIP  = 3'd2;
    localparam logic [2:0] ST_TRUNC_HDR = 3'd3;
    localparam logic [2:0] ST_TRUNC_DAT = 3'd4;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic [15:0] members_seen;
        logic [2:0]  status;
        logic [1:0]  byte_class;
        logic [7:0]  byte_out;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/gzip_member_framer.sv
// Top level of the gzip member framer: front parser, result queue, output stage.
//
//  channel  dir  tdata (low bit up)                        tuser
//  s_       in   byte_in[7:0]                              operation[1:0]
//  m_       out  byte_out[7:0] status[10:8] members[26:11] byte_class[1:0]
//
// One event per cycle: the front state machine labels each request in the cycle it is taken.
// Results reach m_tdata through a two-entry queue and an output register.
// s_tready drops only when the queue is full; the front holds its state meanwhile.
// aresetn is synchronous, active low, and restarts at the fixed header with no member seen.
`default_nettype none
module gzip_member_framer (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [7:0]                   s_tdata,   // byte_in[7:0]
    input  wire  [1:0]                   s_tuser,   // operation[1:0]
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [gmf_pkg::TDATA_W-1:0]  m_tdata,   // byte_out, status, members_seen
    output logic [1:0]                   m_tuser    // byte_class[1:0]
);
    import gmf_pkg::*;

    logic    push_valid, push_ready;
    result_t push_data;
    logic    pop_valid, pop_ready;
    result_t pop_data;

    gmf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_byte    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    gmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gmf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: hdl/gmf_front.sv
// Front part: accepts input events, walks the gzip header state machine, labels each byte.
`default_nettype none
module gmf_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [1:0]            in_op,
    input  wire  [7:0]            in_byte,
    output logic                  push_valid,
    input  wire                   push_ready,
    output gmf_pkg::result_t      push_data
);
    import gmf_pkg::*;

    typedef enum logic [10:0] {
        PH_FIXED      = 11'b000_0000_0001,
        PH_FIXED_BAD  = 11'b000_0000_0010,
        PH_EXTRA_LO   = 11'b000_0000_0100,
        PH_EXTRA_HI   = 11'b000_0000_1000,
        PH_EXTRA_SKIP = 11'b000_0001_0000,
        PH_NAME       = 11'b000_0010_0000,
        PH_COMMENT    = 11'b000_0100_0000,
        PH_HCRC       = 11'b000_1000_0000,
        PH_PAYLOAD    = 11'b001_0000_0000,
        PH_TRAILER    = 11'b010_0000_0000,
        PH_DONE       = 11'b100_0000_0000
    } phase_t;

    localparam logic [7:0] MAGIC0  = 8'h1f;
    localparam logic [7:0] MAGIC1  = 8'h8b;
    localparam logic [7:0] CM_DEFL = 8'h08;
    localparam int FL_HCRC_BIT    = 1;
    localparam int FL_EXTRA_BIT   = 2;
    localparam int FL_NAME_BIT    = 3;
    localparam int FL_COMMENT_BIT = 4;
    localparam logic [3:0] HDR_LAST  = 4'd9;
    localparam logic [3:0] TRL_LAST  = 4'd7;
    localparam logic [2:0] FROM_EXTRA   = 3'd0;
    localparam logic [2:0] FROM_NAME    = 3'd1;
    localparam logic [2:0] FROM_COMMENT = 3'd2;
    localparam logic [2:0] FROM_HCRC    = 3'd3;
    localparam logic [2:0] FROM_NONE    = 3'd4;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] extra_reg, extra_next;
    logic [3:0]  trl_cnt_reg, trl_cnt_next;
    logic [15:0] members_reg, members_next;
    logic [2:0]  status_reg, status_next;

    logic        accept;
    logic        adv;
    logic [2:0]  adv_from;
    logic        bad;
    logic [15:0] extra_hi_val;
    logic [15:0] extra_dec;
    phase_t      adv_phase;

    function automatic phase_t next_part(input logic [2:0] from, input logic [7:0] fl);
        phase_t p;
        if (from == FROM_EXTRA && fl[FL_EXTRA_BIT]) begin
            p = PH_EXTRA_LO;
        end else if (from <= FROM_NAME && fl[FL_NAME_BIT]) begin
            p = PH_NAME;
        end else if (from <= FROM_COMMENT && fl[FL_COMMENT_BIT]) begin
            p = PH_COMMENT;
        end else if (from <= FROM_HCRC && fl[FL_HCRC_BIT]) begin
            p = PH_HCRC;
        end else begin
            p = PH_PAYLOAD;
        end
        return p;
    endfunction

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = accept;
    assign extra_hi_val = {in_byte, extra_reg[7:0]};
    assign extra_dec    = extra_reg - 16'd1;
    assign adv_phase    = next_part(adv_from, flags_reg);

    always_comb begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        flags_next   = flags_reg;
        extra_next   = extra_reg;
        trl_cnt_next = trl_cnt_reg;
        members_next = members_reg;
        status_next  = status_reg;
        adv          = 1'b0;
        adv_from     = FROM_NONE;
        bad          = 1'b0;
        push_data.byte_out   = 8'd0;
        push_data.byte_class = CLS_IGNORED;

        unique case (in_op)
            OP_DATA: begin
                push_data.byte_out = in_byte;
                unique case (phase_reg)
                    PH_FIXED, PH_FIXED_BAD: begin
                        push_data.byte_class = CLS_HEADER;
                        bad = (phase_reg == PH_FIXED_BAD)
                            || (hdr_idx_reg == 4'd0 && in_byte != MAGIC0)
                            || (hdr_idx_reg == 4'd1 && in_byte != MAGIC1)
                            || (hdr_idx_reg == 4'd2 && in_byte != CM_DEFL);
                        if (bad) begin
                            phase_next = PH_FIXED_BAD;
                        end
                        if (hdr_idx_reg == 4'd3) begin
                            flags_next = in_byte;
                        end
                        if (hdr_idx_reg >= HDR_LAST) begin
                            hdr_idx_next = 4'd0;
                            if (bad) begin
                                phase_next  = PH_DONE;
                                status_next = (members_reg != 16'd0) ? ST_CLEAN : ST_NOT_GZIP;
                            end else begin
                                adv      = 1'b1;
                                adv_from = FROM_EXTRA;
                            end
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 4'd1;
                        end
                    end
                    PH_EXTRA_LO: begin
                        push_data.byte_class = CLS_HEADER;
                        extra_next = {8'd0, in_byte};
                        phase_next = PH_EXTRA_HI;
                    end
                    PH_EXTRA_HI: begin
                        push_data.byte_class = CLS_HEADER;
                        extra_next = extra_hi_val;
                        if (extra_hi_val == 16'd0) begin
                            adv      = 1'b1;
                            adv_from = FROM_NAME;
                        end else begin
                            phase_next = PH_EXTRA_SKIP;
                        end
                    end
                    PH_EXTRA_SKIP: begin
                        push_data.byte_class = CLS_HEADER;
                        extra_next = extra_dec;
                        if (extra_dec == 16'd0) begin
                            adv      = 1'b1;
                            adv_from = FROM_NAME;
                        end
                    end
                    PH_NAME: begin
                        push_data.byte_class = CLS_HEADER;
                        if (in_byte == 8'd0) begin
                            adv      = 1'b1;
                            adv_from = FROM_COMMENT;
                        end
                    end
                    PH_COMMENT: begin
                        push_data.byte_class = CLS_HEADER;
                        if (in_byte == 8'd0) begin
                            adv      = 1'b1;
                            adv_from = FROM_HCRC;
                        end
                    end
                    PH_HCRC: begin
                        push_data.byte_class = CLS_HEADER;
                        if (hdr_idx_reg >= 4'd1) begin
                            hdr_idx_next = 4'd0;
                            adv          = 1'b1;
                            adv_from     = FROM_NONE;
                        end else begin
                            hdr_idx_next = 4'd1;
                        end
                    end
                    PH_PAYLOAD: begin
                        push_data.byte_class = CLS_PAYLOAD;
                    end
                    PH_TRAILER: begin
                        push_data.byte_class = CLS_TRAILER;
                        if (trl_cnt_reg >= TRL_LAST) begin
                            trl_cnt_next = 4'd0;
                            hdr_idx_next = 4'd0;
                            phase_next   = PH_FIXED;
                        end else begin
                            trl_cnt_next = trl_cnt_reg + 4'd1;
                        end
                    end
                    default: begin
                        push_data.byte_class = CLS_IGNORED;
                    end
                endcase
            end
            OP_END: begin
                unique case (phase_reg)
                    PH_FIXED: begin
                        phase_next  = PH_DONE;
                        status_next = (hdr_idx_reg == 4'd0) ? ST_CLEAN : ST_TRUNC_HDR;
                    end
                    PH_FIXED_BAD, PH_EXTRA_LO, PH_EXTRA_HI, PH_EXTRA_SKIP,
                    PH_NAME, PH_COMMENT, PH_HCRC: begin
                        phase_next  = PH_DONE;
                        status_next = ST_TRUNC_HDR;
                    end
                    PH_PAYLOAD: begin
                        phase_next  = PH_DONE;
                        status_next = ST_TRUNC_DAT;
                    end
                    PH_TRAILER: begin
                        phase_next  = PH_DONE;
                        status_next = ST_CLEAN;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            OP_INFL_END: begin
                if (phase_reg == PH_PAYLOAD) begin
                    phase_next   = PH_TRAILER;
                    trl_cnt_next = 4'd0;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (adv) begin
            phase_next = adv_phase;
            if (adv_phase == PH_PAYLOAD && members_reg != 16'hFFFF) begin
                members_next = members_reg + 16'd1;
            end
        end

        push_data.status       = status_next;
        push_data.members_seen = members_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIXED;
            hdr_idx_reg <= 4'd0;
            flags_reg   <= 8'd0;
            extra_reg   <= 16'd0;
            trl_cnt_reg <= 4'd0;
            members_reg <= 16'd0;
            status_reg  <= ST_OK;
        end else if (accept) begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            flags_reg   <= flags_next;
            extra_reg   <= extra_next;
            trl_cnt_reg <= trl_cnt_next;
            members_reg <= members_next;
            status_reg  <= status_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gmf_queue.sv
// Two-entry result queue between the front and back parts.
`default_nettype none
module gmf_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  gmf_pkg::result_t      push_data,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output gmf_pkg::result_t      pop_data
);
    import gmf_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gmf_back.sv
// Back part: output register that presents labelled bytes on the result stream.
`default_nettype none
module gmf_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          pop_valid,
    output logic                         pop_ready,
    input  gmf_pkg::result_t             pop_data,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [gmf_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser
);
    import gmf_pkg::*;

    localparam int PAY_W = $bits(result_t) - 2;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop_ready  = !valid_reg || m_tready;
    assign valid_next = pop_ready ? pop_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            data_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.byte_class;
    assign m_tdata  = {{(TDATA_W - PAY_W){1'b0}},
                       data_reg.members_seen, data_reg.status, data_reg.byte_out};

endmodule
`default_nettype wire

FILE: hdl/gmf_checker.sv
// Port-level checker for the gzip member framer, bound to the top level.
`default_nettype none
module gmf_port_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [gmf_pkg::TDATA_W-1:0]   m_tdata,
    input wire [1:0]                    m_tuser
);
    import gmf_pkg::*;

    logic        out_acc;
    logic        seen_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [15:0] members_reg;
    logic [2:0]  cur_status;
    logic [15:0] cur_members;

    assign out_acc     = m_tvalid && m_tready;
    assign cur_status  = m_tdata[10:8];
    assign cur_members = m_tdata[26:11];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            members_reg <= 16'd0;
        end else if (out_acc) begin
            seen_reg    <= 1'b1;
            done_reg    <= (cur_status != ST_OK);
            status_reg  <= cur_status;
            members_reg <= cur_members;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && done_reg |-> cur_status == status_reg && m_tuser == CLS_IGNORED)
        else $error("event after stream end not ignored or status changed");

    a_members_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && seen_reg |-> cur_members >= members_reg
            && cur_members - members_reg <= 16'd1)
        else $error("member count stepped wrongly");

    a_payload_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && (m_tuser == CLS_PAYLOAD || m_tuser == CLS_TRAILER) |->
            cur_status == ST_OK && cur_members != 16'd0)
        else $error("payload or trailer byte outside an accepted member");

endmodule

bind gzip_member_framer gmf_port_checker u_gmf_checker (.*);
`default_nettype wire

FILE: tb/gmf_tb_pkg.sv
// Gzip format constants shared by the framer testbench and its checker.
`timescale 1ns / 1ps
package gmf_tb_pkg;

    localparam logic [7:0] GZ_ID1        = 8'h1f;
    localparam logic [7:0] GZ_ID2        = 8'h8b;
    localparam logic [7:0] GZ_CM_DEFLATE = 8'h08;

    localparam logic [7:0] FLG_HCRC    = 8'h02;
    localparam logic [7:0] FLG_EXTRA   = 8'h04;
    localparam logic [7:0] FLG_NAME    = 8'h08;
    localparam logic [7:0] FLG_COMMENT = 8'h10;

    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam int FIXED_LEN   = 10;
    localparam int FLG_POS     = 3;
    localparam int TRAILER_LEN = 8;

endpackage

FILE: tb/gmf_checker.sv
// Checker for the gzip member framer: predicts each byte label and compares the results.
`timescale 1ns / 1ps
module gmf_checker
    import gmf_pkg::*;
    import gmf_tb_pkg::*;
(
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    input  wire                         s_tready,
    input  wire  [7:0]                  s_tdata,
    input  wire  [1:0]                  s_tuser,
    input  wire                         m_tvalid,
    input  wire                         m_tready,
    input  wire  [gmf_pkg::TDATA_W-1:0] m_tdata,
    input  wire  [1:0]                  m_tuser,
    output int                          mismatches,
    output int                          outstanding
);

    typedef enum logic [3:0] {
        FR_FIXED,
        FR_FIXED_BAD,
        FR_EXTRA_LO,
        FR_EXTRA_HI,
        FR_EXTRA_SKIP,
        FR_NAME,
        FR_COMMENT,
        FR_HCRC,
        FR_PAYLOAD,
        FR_TRAILER,
        FR_DONE
    } frame_phase_t;

    localparam int PART_EXTRA   = 0;
    localparam int PART_NAME    = 1;
    localparam int PART_COMMENT = 2;
    localparam int PART_HCRC    = 3;
    localparam int PART_NONE    = 4;

    frame_phase_t fr_phase;
    logic [3:0]   hdr_pos;
    logic [7:0]   hdr_flags;
    logic [15:0]  extra_left;
    logic [3:0]   trl_pos;
    logic [15:0]  member_cnt;
    logic [2:0]   end_status;

    result_t labels_due[$];

    task automatic reset_framer();
        fr_phase   = FR_FIXED;
        hdr_pos    = '0;
        hdr_flags  = '0;
        extra_left = '0;
        trl_pos    = '0;
        member_cnt = '0;
        end_status = ST_OK;
    endtask

    task automatic close_stream(input logic [2:0] st);
        end_status = st;
        fr_phase   = FR_DONE;
    endtask

    task automatic next_part(input int from);
        if (from <= PART_EXTRA && (hdr_flags & FLG_EXTRA) != 0) begin
            fr_phase = FR_EXTRA_LO;
        end else if (from <= PART_NAME && (hdr_flags & FLG_NAME) != 0) begin
            fr_phase = FR_NAME;
        end else if (from <= PART_COMMENT && (hdr_flags & FLG_COMMENT) != 0) begin
            fr_phase = FR_COMMENT;
        end else if (from <= PART_HCRC && (hdr_flags & FLG_HCRC) != 0) begin
            fr_phase = FR_HCRC;
            hdr_pos  = '0;
        end else begin
            if (member_cnt != 16'hFFFF) member_cnt++;
            fr_phase = FR_PAYLOAD;
        end
    endtask

    task automatic classify_event(input logic [1:0] op, input logic [7:0] b,
                                  output result_t r);
        r.byte_out   = 8'h00;
        r.byte_class = CLS_IGNORED;
        if (op == OP_DATA) begin
            r.byte_out = b;
            case (fr_phase)
                FR_FIXED, FR_FIXED_BAD: begin
                    r.byte_class = CLS_HEADER;
                    if ((hdr_pos == 0 && b != GZ_ID1) || (hdr_pos == 1 && b != GZ_ID2) ||
                        (hdr_pos == 2 && b != GZ_CM_DEFLATE))
                        fr_phase = FR_FIXED_BAD;
                    if (hdr_pos == FLG_POS) hdr_flags = b;
                    if (hdr_pos >= FIXED_LEN - 1) begin
                        hdr_pos = '0;
                        if (fr_phase == FR_FIXED_BAD)
                            close_stream(member_cnt != 0 ? ST_CLEAN : ST_NOT_GZIP);
                        else
                            next_part(PART_EXTRA);
                    end else begin
                        hdr_pos++;
                    end
                end
                FR_EXTRA_LO: begin
                    r.byte_class = CLS_HEADER;
                    extra_left   = {8'h00, b};
                    fr_phase     = FR_EXTRA_HI;
                end
                FR_EXTRA_HI: begin
                    r.byte_class = CLS_HEADER;
                    extra_left   = {b, extra_left[7:0]};
                    if (extra_left == 0) next_part(PART_NAME);
                    else fr_phase = FR_EXTRA_SKIP;
                end
                FR_EXTRA_SKIP: begin
                    r.byte_class = CLS_HEADER;
                    extra_left--;
                    if (extra_left == 0) next_part(PART_NAME);
                end
                FR_NAME: begin
                    r.byte_class = CLS_HEADER;
                    if (b == 8'h00) next_part(PART_COMMENT);
                end
                FR_COMMENT: begin
                    r.byte_class = CLS_HEADER;
                    if (b == 8'h00) next_part(PART_HCRC);
                end
                FR_HCRC: begin
                    r.byte_class = CLS_HEADER;
                    if (hdr_pos >= 1) begin
                        hdr_pos = '0;
                        next_part(PART_NONE);
                    end else begin
                        hdr_pos = 4'd1;
                    end
                end
                FR_PAYLOAD: begin
                    r.byte_class = CLS_PAYLOAD;
                end
                FR_TRAILER: begin
                    r.byte_class = CLS_TRAILER;
                    if (trl_pos >= TRAILER_LEN - 1) begin
                        trl_pos  = '0;
                        hdr_pos  = '0;
                        fr_phase = FR_FIXED;
                    end else begin
                        trl_pos++;
                    end
                end
                default: begin
                    r.byte_class = CLS_IGNORED;
                end
            endcase
        end else if (op == OP_END) begin
            case (fr_phase)
                FR_FIXED: begin
                    close_stream(hdr_pos == 0 ? ST_CLEAN : ST_TRUNC_HDR);
                end
                FR_FIXED_BAD, FR_EXTRA_LO, FR_EXTRA_HI, FR_EXTRA_SKIP,
                FR_NAME, FR_COMMENT, FR_HCRC: begin
                    close_stream(ST_TRUNC_HDR);
                end
                FR_PAYLOAD: begin
                    close_stream(ST_TRUNC_DAT);
                end
                FR_TRAILER: begin
                    close_stream(ST_CLEAN);
                end
                default: begin
                end
            endcase
        end else if (op == OP_INFL_END) begin
            if (fr_phase == FR_PAYLOAD) begin
                fr_phase = FR_TRAILER;
                trl_pos  = '0;
            end
        end
        r.status       = end_status;
        r.members_seen = member_cnt;
    endtask

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            reset_framer();
            labels_due.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.byte_out     = m_tdata[7:0];
                got.status       = m_tdata[10:8];
                got.members_seen = m_tdata[26:11];
                got.byte_class   = m_tuser;
                if (labels_due.size() == 0) begin
                    flag_mismatch("unrequested result", int'(m_tdata), 0);
                end else begin
                    want = labels_due.pop_front();
                    if (got.byte_out !== want.byte_out)
                        flag_mismatch("byte_out", int'(got.byte_out), int'(want.byte_out));
                    if (got.byte_class !== want.byte_class)
                        flag_mismatch("byte_class", int'(got.byte_class),
                                      int'(want.byte_class));
                    if (got.status !== want.status)
                        flag_mismatch("status", int'(got.status), int'(want.status));
                    if (got.members_seen !== want.members_seen)
                        flag_mismatch("members_seen", int'(got.members_seen),
                                      int'(want.members_seen));
                    if (m_tdata[gmf_pkg::TDATA_W-1:27] !== '0)
                        flag_mismatch("tdata padding",
                                      int'(m_tdata[gmf_pkg::TDATA_W-1:27]), 0);
                end
            end
            if (s_tvalid && s_tready) begin
                classify_event(s_tuser, s_tdata, want);
                labels_due.push_back(want);
            end
        end
        outstanding = labels_due.size();
    end

endmodule

FILE: tb/tb_gzip_member_framer.sv
// Testbench top for the gzip member framer: clock, reset, gzip stream stimulus and verdict.
`timescale 1ns / 1ps
module tb_gzip_member_framer;
    import gmf_pkg::*;
    import gmf_tb_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1750;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        END_BETWEEN,
        END_IN_FIXED,
        END_IN_BAD_FIXED,
        END_TRAILING_JUNK,
        END_IN_NAME,
        END_IN_PAYLOAD,
        END_IN_TRAILER
    } stream_end_t;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = 8'h00;
    logic [1:0]                  s_tuser  = OP_DATA;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [gmf_pkg::TDATA_W-1:0] m_tdata;
    logic [1:0]                  m_tuser;

    int mismatches;
    int outstanding;
    int sent         = 0;
    int src_gap_pct  = 7;
    int sink_gap_pct = 70;
    int noise_pct    = 0;
    int quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    gzip_member_framer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gmf_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(negedge aclk) begin
        m_tready <= (int'($urandom_range(0, 99)) >= sink_gap_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [7:0] b);
        if (sent < ITEM_TARGET / 3) begin
            src_gap_pct  = 7;
            sink_gap_pct = 70;
        end else if (sent < 2 * ITEM_TARGET / 3) begin
            src_gap_pct  = 70;
            sink_gap_pct = 7;
        end else begin
            src_gap_pct  = 0;
            sink_gap_pct = 0;
        end
        while (int'($urandom_range(0, 99)) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    // insert an ignored request ahead of the real one now and then
    task automatic send_noisy(input logic [1:0] op, input logic [7:0] b, input bit in_payload);
        if (int'($urandom_range(0, 99)) < noise_pct) begin
            if (in_payload || $urandom_range(0, 1) == 0)
                send_event(OP_RSVD, 8'($urandom_range(0, 255)));
            else
                send_event(OP_INFL_END, 8'($urandom_range(0, 255)));
        end
        send_event(op, b);
    endtask

    task automatic send_fixed(input logic [7:0] flg, input int nbytes, input bit corrupt);
        logic [7:0] hdr [FIXED_LEN];
        int         k;
        hdr[0] = GZ_ID1;
        hdr[1] = GZ_ID2;
        hdr[2] = GZ_CM_DEFLATE;
        hdr[3] = flg;
        for (k = 4; k < FIXED_LEN; k++) hdr[k] = 8'($urandom_range(0, 255));
        if (corrupt) begin
            k = int'($urandom_range(0, 2));
            hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < nbytes; k++) send_noisy(OP_DATA, hdr[k], 1'b0);
    endtask

    task automatic send_string(input int len);
        int k;
        for (k = 0; k < len; k++) send_noisy(OP_DATA, 8'($urandom_range(1, 255)), 1'b0);
        send_noisy(OP_DATA, 8'h00, 1'b0);
    endtask

    task automatic send_member(input logic [7:0] flg, input logic [15:0] xlen,
                               input int name_len, input int cmt_len, input int pay_len);
        int k;
        send_fixed(flg, FIXED_LEN, 1'b0);
        if ((flg & FLG_EXTRA) != 0) begin
            send_noisy(OP_DATA, xlen[7:0], 1'b0);
            send_noisy(OP_DATA, xlen[15:8], 1'b0);
            for (k = 0; k < int'(xlen); k++)
                send_noisy(OP_DATA, 8'($urandom_range(0, 255)), 1'b0);
        end
        if ((flg & FLG_NAME) != 0) send_string(name_len);
        if ((flg & FLG_COMMENT) != 0) send_string(cmt_len);
        if ((flg & FLG_HCRC) != 0) begin
            for (k = 0; k < 2; k++) send_noisy(OP_DATA, 8'($urandom_range(0, 255)), 1'b0);
        end
        for (k = 0; k < pay_len; k++) send_noisy(OP_DATA, 8'($urandom_range(0, 255)), 1'b1);
        send_noisy(OP_INFL_END, 8'($urandom_range(0, 255)), 1'b1);
        for (k = 0; k < TRAILER_LEN; k++)
            send_noisy(OP_DATA, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin : stimulus
        stream_end_t tail;
        int          k;
        int          n;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ignored events before any header, then a member with every flag set
        send_event(OP_RSVD, 8'hFF);
        send_event(OP_INFL_END, 8'h00);
        send_member(8'hFF, 16'd2, 1, 0, 2);

        while (sent < ITEM_TARGET) begin
            noise_pct = ($urandom_range(0, 4) == 0) ? 25 : 0;
            send_member(8'($urandom_range(0, 255)),
                        16'(($urandom_range(0, 39) == 0) ? $urandom_range(0, 300)
                                                         : $urandom_range(0, 6)),
                        int'($urandom_range(0, 8)), int'($urandom_range(0, 8)),
                        int'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                         : $urandom_range(0, 16)));
        end

        // end the stream in one of its phases
        tail = stream_end_t'($urandom_range(0, 6));
        case (tail)
            END_IN_FIXED: begin
                send_fixed(8'($urandom_range(0, 255)),
                           int'($urandom_range(1, FIXED_LEN - 1)), 1'b0);
            end
            END_IN_BAD_FIXED: begin
                send_fixed(8'($urandom_range(0, 255)),
                           int'($urandom_range(3, FIXED_LEN - 1)), 1'b1);
            end
            END_TRAILING_JUNK: begin
                send_fixed(8'($urandom_range(0, 255)), FIXED_LEN, 1'b1);
                n = int'($urandom_range(0, 6));
                for (k = 0; k < n; k++) send_event(OP_DATA, 8'($urandom_range(0, 255)));
            end
            END_IN_NAME: begin
                send_fixed(FLG_NAME, FIXED_LEN, 1'b0);
                n = int'($urandom_range(0, 5));
                for (k = 0; k < n; k++) send_event(OP_DATA, 8'($urandom_range(1, 255)));
            end
            END_IN_PAYLOAD: begin
                send_fixed(8'h00, FIXED_LEN, 1'b0);
                n = int'($urandom_range(0, 5));
                for (k = 0; k < n; k++)
                    send_noisy(OP_DATA, 8'($urandom_range(0, 255)), 1'b1);
            end
            END_IN_TRAILER: begin
                send_fixed(8'h00, FIXED_LEN, 1'b0);
                send_event(OP_INFL_END, 8'($urandom_range(0, 255)));
                n = int'($urandom_range(0, TRAILER_LEN - 1));
                for (k = 0; k < n; k++) send_event(OP_DATA, 8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
        send_event(OP_END, 8'($urandom_range(0, 255)));

        // everything after the end is ignored
        for (k = 0; k < 12; k++)
            send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/gmf_pkg.sv
hdl/gmf_front.sv
hdl/gmf_queue.sv
hdl/gmf_back.sv
hdl/gzip_member_framer.sv
hdl/gmf_checker.sv
tb/gmf_tb_pkg.sv
tb/gmf_checker.sv
tb/tb_gzip_member_framer.sv
